@@ rtl/core/scaled_glyph_row_rasterizer_defines.svh @@
// Assertion helpers used by the rasteriser RTL.
`ifndef SCALED_GLYPH_ROW_RASTERIZER_DEFINES_SVH
`define SCALED_GLYPH_ROW_RASTERIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sgrr_pkg.sv @@
package sgrr_pkg;

	localparam logic [7:0] GLYPH_FIRST = 8'h20;
	localparam logic [7:0] GLYPH_LAST  = 8'h7E;
	localparam logic [7:0] GLYPH_SUBST = 8'h3F;
	localparam logic [2:0] GLYPH_COLS  = 3'd5;
	localparam logic [2:0] CELL_COLS   = 3'd6;
	localparam logic [2:0] GLYPH_ROWS  = 3'd7;

	// register indexes on the configuration port
	localparam logic [1:0] REG_FG_COLOR = 2'd0;
	localparam logic [1:0] REG_BG_COLOR = 2'd1;
	localparam logic [1:0] REG_SCALE    = 2'd2;

	typedef logic [6:0]  glyph_idx_t;
	typedef logic [39:0] glyph_word_t;   // column 0 in the top byte
	typedef logic [6:0]  dot_bits_t;     // bit 0 is the top dot

	typedef struct packed {
		logic [2:0] dot_row;
		logic       oor;
		logic [2:0] scale;
	} row_ctx_t;

	function automatic glyph_word_t font_glyph(input glyph_idx_t idx);
		glyph_word_t w;
		case (idx)
			7'd0:  w = 40'h0000000000;
			7'd1:  w = 40'h00005F0000;
			7'd2:  w = 40'h0007000700;
			7'd3:  w = 40'h147F147F14;
			7'd4:  w = 40'h242A7F2A12;
			7'd5:  w = 40'h2313086462;
			7'd6:  w = 40'h3649552250;
			7'd7:  w = 40'h0005030000;
			7'd8:  w = 40'h001C224100;
			7'd9:  w = 40'h0041221C00;
			7'd10: w = 40'h14083E0814;
			7'd11: w = 40'h08083E0808;
			7'd12: w = 40'h0050300000;
			7'd13: w = 40'h0808080808;
			7'd14: w = 40'h0060600000;
			7'd15: w = 40'h2010080402;
			7'd16: w = 40'h3E5149453E;
			7'd17: w = 40'h00427F4000;
			7'd18: w = 40'h4261514946;
			7'd19: w = 40'h2141454B31;
			7'd20: w = 40'h1814127F10;
			7'd21: w = 40'h2745454539;
			7'd22: w = 40'h3C4A494930;
			7'd23: w = 40'h0171090503;
			7'd24: w = 40'h3649494936;
			7'd25: w = 40'h064949291E;
			7'd26: w = 40'h0036360000;
			7'd27: w = 40'h0056360000;
			7'd28: w = 40'h0814224100;
			7'd29: w = 40'h1414141414;
			7'd30: w = 40'h0041221408;
			7'd31: w = 40'h0201510906;
			7'd32: w = 40'h324979413E;
			7'd33: w = 40'h7E1111117E;
			7'd34: w = 40'h7F49494936;
			7'd35: w = 40'h3E41414122;
			7'd36: w = 40'h7F4141221C;
			7'd37: w = 40'h7F49494941;
			7'd38: w = 40'h7F09090901;
			7'd39: w = 40'h3E4149497A;
			7'd40: w = 40'h7F0808087F;
			7'd41: w = 40'h00417F4100;
			7'd42: w = 40'h2040413F01;
			7'd43: w = 40'h7F08142241;
			7'd44: w = 40'h7F40404040;
			7'd45: w = 40'h7F020C027F;
			7'd46: w = 40'h7F0408107F;
			7'd47: w = 40'h3E4141413E;
			7'd48: w = 40'h7F09090906;
			7'd49: w = 40'h3E4151215E;
			7'd50: w = 40'h7F09192946;
			7'd51: w = 40'h4649494931;
			7'd52: w = 40'h01017F0101;
			7'd53: w = 40'h3F4040403F;
			7'd54: w = 40'h1F2040201F;
			7'd55: w = 40'h3F4038403F;
			7'd56: w = 40'h6314081463;
			7'd57: w = 40'h0708700807;
			7'd58: w = 40'h6151494543;
			7'd59: w = 40'h007F414100;
			7'd60: w = 40'h0204081020;
			7'd61: w = 40'h0041417F00;
			7'd62: w = 40'h0402010204;
			7'd63: w = 40'h4040404040;
			7'd64: w = 40'h0001020400;
			7'd65: w = 40'h2054545478;
			7'd66: w = 40'h7F48444438;
			7'd67: w = 40'h3844444420;
			7'd68: w = 40'h384444487F;
			7'd69: w = 40'h3854545418;
			7'd70: w = 40'h087E090102;
			7'd71: w = 40'h0C5252523E;
			7'd72: w = 40'h7F08040478;
			7'd73: w = 40'h00447D4000;
			7'd74: w = 40'h2040443D00;
			7'd75: w = 40'h7F10284400;
			7'd76: w = 40'h00417F4000;
			7'd77: w = 40'h7C04180478;
			7'd78: w = 40'h7C08040478;
			7'd79: w = 40'h3844444438;
			7'd80: w = 40'h7C14141408;
			7'd81: w = 40'h081414187C;
			7'd82: w = 40'h7C08040408;
			7'd83: w = 40'h4854545420;
			7'd84: w = 40'h043F444020;
			7'd85: w = 40'h3C4040207C;
			7'd86: w = 40'h1C2040201C;
			7'd87: w = 40'h3C4030403C;
			7'd88: w = 40'h4428102844;
			7'd89: w = 40'h0C5050503C;
			7'd90: w = 40'h4464544C44;
			7'd91: w = 40'h0008364100;
			7'd92: w = 40'h00007F0000;
			7'd93: w = 40'h0041360800;
			7'd94: w = 40'h08082A1C08;
			default: w = 40'h0000000000;
		endcase
		return w;
	endfunction

	function automatic dot_bits_t glyph_column(input glyph_word_t w, input logic [2:0] col);
		dot_bits_t b;
		case (col)
			3'd0: b = w[38:32];
			3'd1: b = w[30:24];
			3'd2: b = w[22:16];
			3'd3: b = w[14:8];
			3'd4: b = w[6:0];
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/core/sgrr_font_rom.sv @@
module sgrr_font_rom import sgrr_pkg::*; (
	input  logic        clk,
	input  logic        rd_en,
	input  glyph_idx_t  rd_addr,
	output glyph_word_t rd_data
);

	// synchronous glyph store, one five-column glyph per word; data holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= font_glyph(rd_addr);
		end
	end

endmodule

@@ rtl/core/scaled_glyph_row_rasterizer.sv @@
// Scaled 5x7 glyph row rasteriser.
// Input channel (in_valid/in_ready): one item names a character code and a pixel
// row of its scaled cell. Output channel (out_valid/out_ready): one item per pixel,
// RGB565 colour, last_pixel on the final pixel, row_out_of_range on every pixel of
// a row at or beyond seven times the scale.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 foreground
// colour, 1 background colour, 2 scale; other indexes are ignored. Write it only
// while no row is in flight.
// On acceptance the glyph ROM word and the row context are registered; the first
// pixel is then loaded into the output register once that register is free or taken.
// Throughput: one row gives 6*s pixels, where s is the effective scale (0 reads as
// 1, clamped to MAX_SCALE): the glyph ROM read, then one pixel per cycle from the
// column/sub-column counters while the receiver does not stall. A new item is taken
// as soon as the last pixel of the previous row sits in the output register.
// Reset: colours go to white on black, scale to 1, the sequencer to idle and the
// output register empty. There is no clearing pass: the glyph ROM is constant.
// A stalled receiver holds the output register and freezes the pixel counters.
`include "scaled_glyph_row_rasterizer_defines.svh"

module scaled_glyph_row_rasterizer import sgrr_pkg::*; #(
	parameter int MAX_SCALE = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// row requests
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic [5:0]  row_index,
	// pixels
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_color,
	output logic        last_pixel,
	output logic        row_out_of_range
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic        state_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;
	logic [2:0]  scale_q;
	row_ctx_t    ctx_q;
	logic [2:0]  col_q;
	logic [2:0]  sub_q;

	logic        out_valid_q;
	logic [15:0] pixel_color_q;
	logic        last_pixel_q;
	logic        oor_q;

	logic        in_fire;
	logic        emit;
	logic        sub_end;
	logic        row_last;
	logic        dot_on;
	logic [2:0]  eff_scale;
	row_ctx_t    ctx_d;
	glyph_idx_t  glyph_idx;
	glyph_word_t glyph_word;
	dot_bits_t   col_bits;

	logic        row_at_start;
	logic        row_done;
	logic        cnt_in_cell;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	// Effective scale: zero reads as one, clamp at MAX_SCALE.
	always_comb begin
		eff_scale = scale_q;
		if (scale_q == 3'd0) begin
			eff_scale = 3'd1;
		end else if (32'(scale_q) > MAX_SCALE) begin
			eff_scale = 3'(MAX_SCALE);
		end
	end

	// Row context: dot row is the count of multiples of the scale at or below the row,
	// six independent compares on narrow values.
	always_comb begin
		ctx_d.scale   = eff_scale;
		ctx_d.oor     = ({1'b0, row_index} >= (7'(eff_scale) * 7'(GLYPH_ROWS)));
		ctx_d.dot_row = 3'd0;
		for (int k = 1; k < 7; k++) begin
			if (!ctx_d.oor && ({1'b0, row_index} >= (7'(k) * 7'(eff_scale)))) begin
				ctx_d.dot_row = 3'(k);
			end
		end
	end

	// Unprintable codes fall back to the question mark glyph.
	always_comb begin
		if (char_code < GLYPH_FIRST || char_code > GLYPH_LAST) begin
			glyph_idx = 7'(GLYPH_SUBST - GLYPH_FIRST);
		end else begin
			glyph_idx = 7'(char_code - GLYPH_FIRST);
		end
	end

	// One read per row; the word holds until the next accepted item.
	sgrr_font_rom u_font_rom (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (glyph_idx),
		.rd_data (glyph_word)
	);

	// Pixel selection: spacing column and out-of-range rows are always background.
	always_comb begin
		col_bits = glyph_column(glyph_word, col_q);
		dot_on   = !ctx_q.oor && (col_q < GLYPH_COLS) && col_bits[ctx_q.dot_row];
		sub_end  = (sub_q == ctx_q.scale - 3'd1);
		row_last = sub_end && (col_q == CELL_COLS - 3'd1);
		emit     = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q    <= 16'hFFFF;
			bg_q    <= 16'h0000;
			scale_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FG_COLOR: fg_q    <= cfg_data;
				REG_BG_COLOR: bg_q    <= cfg_data;
				REG_SCALE:    scale_q <= cfg_data[2:0];
				default:      ;
			endcase
		end
	end

	// Sequencer: take a row, then walk columns and sub-columns one pixel a cycle while the output is free or taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= 3'd0;
			sub_q   <= 3'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EMIT;
						col_q   <= 3'd0;
						sub_q   <= 3'd0;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (row_last) begin
							state_q <= ST_IDLE;
							col_q   <= 3'd0;
							sub_q   <= 3'd0;
						end else if (sub_end) begin
							col_q <= col_q + 3'd1;
							sub_q <= 3'd0;
						end else begin
							sub_q <= sub_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the row context on acceptance.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctx_q <= ctx_d;
		end
	end

	// Output register: load on emit, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_color_q <= dot_on ? fg_q : bg_q;
			last_pixel_q  <= row_last;
			oor_q         <= ctx_q.oor;
		end
	end

	assign out_valid        = out_valid_q;
	assign pixel_color      = pixel_color_q;
	assign last_pixel       = last_pixel_q;
	assign row_out_of_range = oor_q;

	assign row_at_start = (state_q == ST_EMIT) && (col_q == 3'd0) && (sub_q == 3'd0);
	assign row_done     = in_ready && out_valid && last_pixel;
	assign cnt_in_cell  = (col_q < CELL_COLS) && (sub_q < ctx_q.scale);

	// An accepted row starts at its first column and sub-column.
	`SGRR_ASSERT_NEXT(a_row_start, clk, arst_n, in_fire, row_at_start, "row not at column zero")
	// The final pixel of a row frees the input side.
	`SGRR_ASSERT_NEXT(a_row_end, clk, arst_n, emit && row_last, row_done, "busy after last pixel")
	// Counters stay inside the scaled cell.
	`SGRR_ASSERT_NOW(a_cnt_range, clk, arst_n, state_q == ST_EMIT, cnt_in_cell, "counters off cell")

endmodule
